>>> rtl/cpl_pkg.sv
// cpl_pkg: widths, fixed-point constants, arctangent table and saturation helper
// for the cell parameter to lattice matrix pipeline
// no dependencies
package cpl_pkg;

  // default values of the top-level parameters
  localparam int FRAC_BITS_DEF = 16;
  localparam int TRIG_ITER_DEF = 20;

  // port and datapath widths
  localparam int LEN_W    = 24;
  localparam int ANGLE_W  = 24;
  localparam int OUT_W    = 25;
  localparam int COS_W    = 32;
  localparam int SIN_W    = 31;
  localparam int CORDIC_W = 34;

  // angle to radian conversion: 39-bit dividend divided by 180 through a
  // reciprocal multiply, partial products in one stage and their sum in the next
  localparam int RAD_W          = 39;
  localparam int RAD_DIV_STAGES = 2;
  localparam int RAD_SHIFT      = 47;
  localparam logic [39:0] RAD_RECIP = 40'd781874935308;

  // square root: one result bit per stage over a 64-bit radicand
  localparam int SQRT_STAGES = 32;

  // rounding divider by sin gamma
  localparam int DIV_NUM_W = 56;
  localparam int DIV_LAT   = OUT_W + 3;

  // fixed-point constants
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [29:0] K_Q30  = 30'd652032874;
  localparam logic signed [63:0] Q30_HALF = 64'sh0000_0000_2000_0000;
  localparam logic signed [63:0] Q60_ONE  = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] OUT_MAX  = 64'sd16777215;
  localparam logic signed [63:0] OUT_MIN  = -64'sd16777216;

  // arctangent of 2^-k in Q30
  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,       30'd63,
    30'd31,        30'd15,        30'd8,         30'd4,         30'd2,
    30'd1,         30'd0
  };

  // saturate a wide signed value to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cpl_trig.sv
// cpl_trig: pipelined cosine and sine of an angle in degrees, Q30 results
// folds to [0, 90] degrees, converts to radians, then runs a rotation cordic
// depends on cpl_pkg
module cpl_trig
  import cpl_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                    clk,
  input  logic [ANGLE_W-1:0]      angle,
  output logic signed [COS_W-1:0] cos_out,
  output logic [SIN_W-1:0]        sin_out
);

  localparam int RW = FRAC_BITS + 7;
  localparam int CW = (FRAC_BITS + 8 > ANGLE_W) ? FRAC_BITS + 8 : ANGLE_W;
  localparam int PW = RW + 32;
  localparam int PH_W  = RAD_W - 20;
  localparam int SUM_W = RAD_W + 40;
  localparam logic [CW-1:0] FULL  = CW'(180) << FRAC_BITS;
  localparam logic [CW-1:0] RIGHT = CW'(90) << FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] UNIT = CORDIC_W'(64'd1 << 30);
  localparam logic [SIN_W-1:0] ONE31 = {1'b1, {(SIN_W-1){1'b0}}};

  typedef struct packed {
    logic obtuse;
    logic zero;
    logic right;
  } flags_t;

  function automatic logic [SIN_W-1:0] clamp_unit(input logic signed [CORDIC_W-1:0] v);
    logic [SIN_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > UNIT) begin
      r = ONE31;
    end else begin
      r = v[SIN_W-1:0];
    end
    return r;
  endfunction

  // clamp to 180 degrees and fold into the first quadrant
  logic [CW-1:0] ang_clip;
  logic [CW-1:0] ang_fold;
  logic          ang_obt;

  always_comb begin
    ang_clip = (CW'(angle) > FULL) ? FULL : CW'(angle);
    if (ang_clip > RIGHT) begin
      ang_fold = FULL - ang_clip;
      ang_obt  = 1'b1;
    end else begin
      ang_fold = ang_clip;
      ang_obt  = 1'b0;
    end
  end

  logic [RW-1:0] fold1;
  flags_t        flg1;

  always_ff @(posedge clk) begin
    fold1 <= ang_fold[RW-1:0];
    flg1  <= '{obtuse: ang_obt, zero: (ang_fold == '0), right: (ang_fold == RIGHT)};
  end

  // degrees times pi
  logic [PW-1:0] prod2;
  flags_t        flg2;

  always_ff @(posedge clk) begin
    prod2 <= PW'(fold1) * PW'(PI_Q30);
    flg2  <= flg1;
  end

  // floor division by 180: partial products of the reciprocal multiply
  logic [RAD_W-1:0]  quo_in;
  logic [PH_W+19:0]  pp_hh;
  logic [PH_W+19:0]  pp_hl;
  logic [39:0]       pp_lh;
  logic [39:0]       pp_ll;
  flags_t            flg3;

  assign quo_in = prod2[FRAC_BITS +: RAD_W];

  always_ff @(posedge clk) begin
    pp_hh <= quo_in[RAD_W-1:20] * RAD_RECIP[39:20];
    pp_hl <= quo_in[RAD_W-1:20] * RAD_RECIP[19:0];
    pp_lh <= quo_in[19:0] * RAD_RECIP[39:20];
    pp_ll <= quo_in[19:0] * RAD_RECIP[19:0];
    flg3  <= flg2;
  end

  // sum of the partial products, quotient in the top bits
  logic [SUM_W-1:0] rad_sum;
  logic [30:0]      rad_z;
  flags_t           rad_f;

  assign rad_sum = (SUM_W'(pp_hh) << 40) + ((SUM_W'(pp_hl) + SUM_W'(pp_lh)) << 20)
                   + SUM_W'(pp_ll);

  always_ff @(posedge clk) begin
    rad_z <= rad_sum[RAD_SHIFT +: 31];
    rad_f <= flg3;
  end

  // rotation cordic, one micro-rotation per stage
  logic signed [CORDIC_W-1:0] cx [TRIG_ITERATIONS];
  logic signed [CORDIC_W-1:0] cy [TRIG_ITERATIONS];
  logic signed [CORDIC_W-1:0] cz [TRIG_ITERATIONS];
  flags_t                     cf [TRIG_ITERATIONS];

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cordic
    localparam logic signed [CORDIC_W-1:0] ATAN_STEP = {{(CORDIC_W-30){1'b0}}, ATAN_TAB[i]};
    logic signed [CORDIC_W-1:0] x_in;
    logic signed [CORDIC_W-1:0] y_in;
    logic signed [CORDIC_W-1:0] z_in;
    flags_t                     f_in;

    if (i == 0) begin : g_first
      assign x_in = {{(CORDIC_W-30){1'b0}}, K_Q30};
      assign y_in = '0;
      assign z_in = {{(CORDIC_W-31){1'b0}}, rad_z};
      assign f_in = rad_f;
    end else begin : g_next
      assign x_in = cx[i-1];
      assign y_in = cy[i-1];
      assign z_in = cz[i-1];
      assign f_in = cf[i-1];
    end

    always_ff @(posedge clk) begin
      if (!z_in[CORDIC_W-1]) begin
        cx[i] <= x_in - (y_in >>> i);
        cy[i] <= y_in + (x_in >>> i);
        cz[i] <= z_in - ATAN_STEP;
      end else begin
        cx[i] <= x_in + (y_in >>> i);
        cy[i] <= y_in - (x_in >>> i);
        cz[i] <= z_in + ATAN_STEP;
      end
      cf[i] <= f_in;
    end
  end

  // clamp, exact quadrant edges and sign of the cosine
  logic [SIN_W-1:0] cos_mag;
  logic [SIN_W-1:0] sin_mag;
  flags_t           fl_last;

  assign fl_last = cf[TRIG_ITERATIONS-1];

  always_comb begin
    if (fl_last.zero) begin
      cos_mag = ONE31;
      sin_mag = '0;
    end else if (fl_last.right) begin
      cos_mag = '0;
      sin_mag = ONE31;
    end else begin
      cos_mag = clamp_unit(cx[TRIG_ITERATIONS-1]);
      sin_mag = clamp_unit(cy[TRIG_ITERATIONS-1]);
    end
  end

  always_ff @(posedge clk) begin
    cos_out <= fl_last.obtuse ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
    sin_out <= sin_mag;
  end

endmodule

>>> rtl/cpl_div.sv
// cpl_div: pipelined rounding divide of a magnitude by sin gamma, one quotient
// bit per stage, sign restored and saturated to the output range
// depends on cpl_pkg
module cpl_div
  import cpl_pkg::*;
(
  input  logic                    clk,
  input  logic [DIV_NUM_W-1:0]    num,
  input  logic [SIN_W-1:0]        den,
  input  logic                    neg,
  output logic signed [OUT_W-1:0] quot
);

  localparam int QB = OUT_W;
  localparam int WW = (DIV_NUM_W + 1 > SIN_W + QB) ? DIV_NUM_W + 1 : SIN_W + QB;
  localparam logic [QB-1:0] MAXQ  = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] HALFQ = {1'b1, {(QB-1){1'b0}}};

  // add half the divisor for round to nearest
  logic [WW-1:0]    n0;
  logic [SIN_W-1:0] d0;
  logic             neg0;

  always_ff @(posedge clk) begin
    n0   <= WW'(num) + WW'(den >> 1);
    d0   <= den;
    neg0 <= neg;
  end

  // quotient too large for the output field
  logic [WW-1:0]    n1;
  logic [SIN_W-1:0] d1;
  logic             neg1;
  logic             ovf1;

  always_ff @(posedge clk) begin
    n1   <= n0;
    d1   <= d0;
    neg1 <= neg0;
    ovf1 <= n0 >= (WW'(d0) << QB);
  end

  // restoring division, most significant quotient bit first
  logic [WW-1:0]    st_r   [QB];
  logic [QB-1:0]    st_q   [QB];
  logic [SIN_W-1:0] st_d   [QB];
  logic             st_neg [QB];
  logic             st_ovf [QB];

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int SH = QB - 1 - j;
    logic [WW-1:0]    r_in;
    logic [QB-1:0]    q_in;
    logic [SIN_W-1:0] d_in;
    logic             neg_in;
    logic             ovf_in;
    logic [WW-1:0]    sub;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_in   = n1;
      assign q_in   = '0;
      assign d_in   = d1;
      assign neg_in = neg1;
      assign ovf_in = ovf1;
    end else begin : g_next
      assign r_in   = st_r[j-1];
      assign q_in   = st_q[j-1];
      assign d_in   = st_d[j-1];
      assign neg_in = st_neg[j-1];
      assign ovf_in = st_ovf[j-1];
    end

    assign sub = WW'(d_in) << SH;
    assign ge  = r_in >= sub;

    always_ff @(posedge clk) begin
      st_r[j]     <= ge ? r_in - sub : r_in;
      st_q[j]     <= q_in | (ge ? (QB'(1) << SH) : '0);
      st_d[j]     <= d_in;
      st_neg[j]   <= neg_in;
      st_ovf[j]   <= ovf_in;
    end
  end

  // restore the sign and saturate
  logic [QB-1:0] q_last;
  logic          neg_last;
  logic          ovf_last;

  assign q_last   = st_q[QB-1];
  assign neg_last = st_neg[QB-1];
  assign ovf_last = st_ovf[QB-1];

  always_ff @(posedge clk) begin
    if (neg_last) begin
      if (ovf_last || q_last > HALFQ) begin
        quot <= $signed(HALFQ);
      end else begin
        quot <= $signed(QB'(~q_last + 1'b1));
      end
    end else begin
      if (ovf_last || q_last[QB-1]) begin
        quot <= $signed(MAXQ);
      end else begin
        quot <= $signed(q_last);
      end
    end
  end

endmodule

>>> rtl/cell_params_to_lattice_matrix.sv
// cell_params_to_lattice_matrix: unit cell lengths and angles to lattice vectors
// latency set by the cordic, the 32-stage square root and the divider;
// one cell accepted per cycle
// busy stays low and results stream out on done, the receiver cannot stall
// synchronous reset clears only the valid bits of the pipeline
// depends on cpl_pkg, cpl_trig, cpl_div
module cell_params_to_lattice_matrix
  import cpl_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [LEN_W-1:0]        length_a,
  input  logic [LEN_W-1:0]        length_b,
  input  logic [LEN_W-1:0]        length_c,
  input  logic [ANGLE_W-1:0]      angle_alpha,
  input  logic [ANGLE_W-1:0]      angle_beta,
  input  logic [ANGLE_W-1:0]      angle_gamma,
  output logic                    done,
  output logic signed [OUT_W-1:0] vec_a_x,
  output logic signed [OUT_W-1:0] vec_b_x,
  output logic signed [OUT_W-1:0] vec_b_y,
  output logic signed [OUT_W-1:0] vec_c_x,
  output logic signed [OUT_W-1:0] vec_c_y,
  output logic signed [OUT_W-1:0] vec_c_z,
  output logic                    invalid
);

  localparam int L_TRIG = TRIG_ITERATIONS + RAD_DIV_STAGES + 3;

  typedef struct packed {
    logic [LEN_W-1:0] a;
    logic [LEN_W-1:0] b;
    logic [LEN_W-1:0] c;
  } len_t;

  typedef struct packed {
    logic                    inv;
    logic signed [OUT_W-1:0] va;
    logic signed [OUT_W-1:0] vbx;
    logic signed [OUT_W-1:0] vby;
    logic signed [OUT_W-1:0] vcx;
    logic [LEN_W-1:0]        c;
    logic [SIN_W-1:0]        sg;
    logic [DIV_NUM_W-1:0]    cn_mag;
    logic                    cn_neg;
  } side_t;

  typedef struct packed {
    logic                    inv;
    logic signed [OUT_W-1:0] va;
    logic signed [OUT_W-1:0] vbx;
    logic signed [OUT_W-1:0] vby;
    logic signed [OUT_W-1:0] vcx;
  } tail_t;

  // the pipeline never stalls, every start is a transfer
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // trigonometry of the three angles
  logic signed [COS_W-1:0] ca;
  logic signed [COS_W-1:0] cb;
  logic signed [COS_W-1:0] cg;
  logic [SIN_W-1:0]        sg;

  cpl_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_alpha (
    .clk(clk), .angle(angle_alpha), .cos_out(ca), .sin_out()
  );
  cpl_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_beta (
    .clk(clk), .angle(angle_beta), .cos_out(cb), .sin_out()
  );
  cpl_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_gamma (
    .clk(clk), .angle(angle_gamma), .cos_out(cg), .sin_out(sg)
  );

  // lengths and valid bits alongside the trig units
  len_t              ln [L_TRIG];
  logic [L_TRIG-1:0] tv;

  always_ff @(posedge clk) begin
    ln[0] <= '{a: length_a, b: length_b, c: length_c};
    for (int k = 1; k < L_TRIG; k++) begin
      ln[k] <= ln[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
    end else begin
      tv <= {tv[L_TRIG-2:0], accept};
    end
  end

  // stage p1: products of cosines, sin gamma and lengths
  logic signed [63:0]  sq_a1, sq_b1, sq_g1, cacb1, cgcb1, bcg1, ccb1;
  logic [LEN_W+SIN_W-1:0] bsg1;
  logic signed [COS_W-1:0] ca1, cg1;
  logic [SIN_W-1:0]    sg1;
  logic [LEN_W-1:0]    a1, c1;
  logic                v1;
  len_t                lt;

  assign lt = ln[L_TRIG-1];

  always_ff @(posedge clk) begin
    sq_a1 <= ca * ca;
    sq_b1 <= cb * cb;
    sq_g1 <= cg * cg;
    cacb1 <= ca * cb;
    cgcb1 <= cg * cb;
    bcg1  <= $signed({1'b0, lt.b}) * cg;
    bsg1  <= lt.b * sg;
    ccb1  <= $signed({1'b0, lt.c}) * cb;
    ca1   <= ca;
    cg1   <= cg;
    sg1   <= sg;
    a1    <= lt.a;
    c1    <= lt.c;
  end

  // stage p2: triple product, partial radicand, rounded entries
  logic signed [63:0]      cacb_sh, cgcb_rnd, n30_full;
  logic [LEN_W+SIN_W:0]    bsg_rnd;
  logic signed [63:0]      m2, s2;
  logic signed [33:0]      n30_2;
  logic signed [OUT_W-1:0] va2, vbx2, vby2, vcx2;
  logic [LEN_W-1:0]        c2;
  logic [SIN_W-1:0]        sg2;
  logic                    v2;

  assign cacb_sh  = cacb1 >>> 30;
  assign cgcb_rnd = (cgcb1 + Q30_HALF) >>> 30;
  assign n30_full = ca1 - cgcb_rnd;
  assign bsg_rnd  = (LEN_W+SIN_W+1)'(bsg1) + (LEN_W+SIN_W+1)'(Q30_HALF);

  always_ff @(posedge clk) begin
    m2    <= $signed(cacb_sh[31:0]) * cg1;
    s2    <= Q60_ONE - sq_a1 - sq_b1 - sq_g1;
    n30_2 <= n30_full[33:0];
    va2   <= $signed({1'b0, a1});
    vbx2  <= sat_out((bcg1 + Q30_HALF) >>> 30);
    vby2  <= sat_out($signed(64'(bsg_rnd >> 30)));
    vcx2  <= sat_out((ccb1 + Q30_HALF) >>> 30);
    c2    <= c1;
    sg2   <= sg1;
  end

  // stage p3: radicand and numerator of vec_c_y
  logic signed [63:0]      rad3, cn3;
  logic signed [OUT_W-1:0] va3, vbx3, vby3, vcx3;
  logic [LEN_W-1:0]        c3;
  logic [SIN_W-1:0]        sg3;
  logic                    v3;

  always_ff @(posedge clk) begin
    rad3 <= s2 + (m2 <<< 1);
    cn3  <= $signed({1'b0, c2}) * n30_2;
    va3  <= va2;
    vbx3 <= vbx2;
    vby3 <= vby2;
    vcx3 <= vcx2;
    c3   <= c2;
    sg3  <= sg2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= tv[L_TRIG-1];
      v2 <= v1;
      v3 <= v2;
    end
  end

  // side data for the square root pipeline
  side_t              side3;
  logic signed [63:0] cn_abs;

  assign cn_abs = cn3[63] ? -cn3 : cn3;

  always_comb begin
    side3.inv    = (sg3 == '0) || rad3[63];
    side3.va     = va3;
    side3.vbx    = vbx3;
    side3.vby    = vby3;
    side3.vcx    = vcx3;
    side3.c      = c3;
    side3.sg     = sg3;
    side3.cn_mag = cn_abs[DIV_NUM_W-1:0];
    side3.cn_neg = cn3[63];
  end

  // integer square root, one result bit per stage
  logic [63:0]            sq_rem [SQRT_STAGES];
  logic [63:0]            sq_res [SQRT_STAGES];
  side_t                  sq_sd  [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] sq_vl;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rem_in;
    logic [63:0] res_in;
    side_t       sd_in;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = side3.inv ? '0 : rad3;
      assign res_in = '0;
      assign sd_in  = side3;
    end else begin : g_next
      assign rem_in = sq_rem[k-1];
      assign res_in = sq_res[k-1];
      assign sd_in  = sq_sd[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        sq_rem[k] <= rem_in - trial;
        sq_res[k] <= (res_in >> 1) + BIT;
      end else begin
        sq_rem[k] <= rem_in;
        sq_res[k] <= res_in >> 1;
      end
      sq_sd[k] <= sd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vl <= '0;
    end else begin
      sq_vl <= {sq_vl[SQRT_STAGES-2:0], v3};
    end
  end

  // stage p5: numerator of vec_c_z
  logic [LEN_W+SIN_W-1:0] cr5;
  side_t                  side5;
  logic                   v5;

  always_ff @(posedge clk) begin
    cr5   <= sq_sd[SQRT_STAGES-1].c * sq_res[SQRT_STAGES-1][SIN_W-1:0];
    side5 <= sq_sd[SQRT_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= sq_vl[SQRT_STAGES-1];
    end
  end

  // divisions by sin gamma
  logic signed [OUT_W-1:0] vcy_q;
  logic signed [OUT_W-1:0] vcz_q;

  cpl_div u_div_y (
    .clk(clk), .num(side5.cn_mag), .den(side5.sg), .neg(side5.cn_neg), .quot(vcy_q)
  );
  cpl_div u_div_z (
    .clk(clk), .num(DIV_NUM_W'(cr5)), .den(side5.sg), .neg(1'b0), .quot(vcz_q)
  );

  // remaining entries wait for the dividers
  tail_t              tl [DIV_LAT];
  logic [DIV_LAT-1:0] tl_v;

  always_ff @(posedge clk) begin
    tl[0] <= '{inv: side5.inv, va: side5.va, vbx: side5.vbx, vby: side5.vby,
               vcx: side5.vcx};
    for (int k = 1; k < DIV_LAT; k++) begin
      tl[k] <= tl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tl_v <= '0;
    end else begin
      tl_v <= {tl_v[DIV_LAT-2:0], v5};
    end
  end

  // result register, zeroed on an invalid cell
  tail_t tail;
  assign tail = tl[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (tail.inv) begin
      vec_a_x <= '0;
      vec_b_x <= '0;
      vec_b_y <= '0;
      vec_c_x <= '0;
      vec_c_y <= '0;
      vec_c_z <= '0;
    end else begin
      vec_a_x <= tail.va;
      vec_b_x <= tail.vbx;
      vec_b_y <= tail.vby;
      vec_c_x <= tail.vcx;
      vec_c_y <= vcy_q;
      vec_c_z <= vcz_q;
    end
    invalid <= tail.inv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tl_v[DIV_LAT-1];
    end
  end

endmodule
